// File: hw/rtl/erd_pkg.sv
package erd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REQ,
    ST_SCAN,
    ST_SEL,
    ST_MOVE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_UP   = 2'd1,
    REQ_DOWN = 2'd2,
    REQ_BOTH = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    MODE_WAITING  = 2'd0,
    MODE_UPDATING = 2'd1,
    MODE_MOVING   = 2'd2,
    MODE_REACHED  = 2'd3
  } mode_t;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_SELECT = 2'd1;
  localparam logic [1:0] FUNC_MOVE   = 2'd2;

  localparam logic [1:0] KIND_UP    = 2'd0;
  localparam logic [1:0] KIND_DOWN  = 2'd1;
  localparam logic [1:0] KIND_CABIN = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

endpackage

// File: hw/rtl/erd_ram.sv
module erd_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/elevator_request_dispatch.sv
// Elevator request dispatch: one word in gives one word out. The per-floor
// request table sits in a small RAM with a valid bit per floor, so it reads
// as empty right after reset with no clearing pass. An add request reads the
// table, then merges and writes back; a move steps the car; and a select has
// the sequencer sweep the table once, one floor per cycle through the RAM read
// port, while a single subtract/compare unit tracks the nearest pending floor,
// the lowest up call at or above the car and the highest down call at or below
// it. The block takes a new word only after the previous result has been taken.
// A write on the configuration port moves the car to the floor on cfg_data,
// clamped to the top floor.
module elevator_request_dispatch #(
  parameter int FLOORS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [3:0] req_floor,
  input  logic [1:0] req_kind,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       doors_open,
  output logic       retarget_wanted,
  output logic       target_valid,
  output logic [3:0] target_floor,
  output logic [3:0] car_floor,
  output logic       arrived,
  output logic       keep_moving,
  output logic       ignored
);
  import erd_pkg::*;

  localparam int FW = $clog2(FLOORS);
  localparam int CW = ((FW > 4) ? FW : 4) + 1;
  localparam logic [CW-1:0] FLOORS_C = CW'(FLOORS);
  localparam logic [CW-1:0] LAST_C   = CW'(FLOORS - 1);
  localparam logic [FW-1:0] LAST     = LAST_C[FW-1:0];

  state_t state, state_next;
  mode_t  mode;
  dir_t   dir;
  logic   goal_vld;
  logic [FW-1:0] goal;
  logic [FW-1:0] car;
  logic [FLOORS-1:0] req_vld;

  logic [1:0]    kind_q;
  logic [FW-1:0] fl_q;
  logic [FW-1:0] tfloor_q;

  logic [FW-1:0] scan_idx;
  logic          rd_vld;
  logic          up_found, dn_found, nr_found;
  logic [FW-1:0] up_floor, dn_floor, nr_floor, best_dist;

  // RAM port
  logic          ram_we;
  logic [FW-1:0] raddr;
  logic [1:0]    rdata;
  req_t          entry;

  // shared subtract/compare unit
  logic [FW-1:0] cmp_a, cmp_b;
  logic [FW:0]   diff, diff_neg;
  logic          a_ge_b, a_eq_b;
  logic [FW-1:0] span;

  logic [CW-1:0] req_floor_c, cfg_c, car_c, tfloor_c;
  logic [FW-1:0] fl_in, cfg_clamped;
  logic          bad_req;

  req_t          want, base, merged;
  logic          at_car;
  logic [FW-1:0] pick;
  logic [FW-1:0] car_step;

  assign req_floor_c = CW'(req_floor);
  assign fl_in       = req_floor_c[FW-1:0];
  assign bad_req     = (req_kind == KIND_BAD) || (req_floor_c >= FLOORS_C);
  assign cfg_c       = CW'(cfg_data);
  assign cfg_clamped = (cfg_c >= FLOORS_C) ? LAST : cfg_c[FW-1:0];

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_DONE);

  assign car_c        = CW'(car);
  assign car_floor    = car_c[3:0];
  assign tfloor_c     = CW'(tfloor_q);
  assign target_floor = tfloor_c[3:0];

  erd_ram #(
    .WIDTH(2),
    .DEPTH(FLOORS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fl_q),
    .wdata(merged),
    .raddr(raddr),
    .rdata(rdata)
  );

  // a floor never written since reset or cleared on arrival reads as none
  assign entry = rd_vld ? req_t'(rdata) : REQ_NONE;

  always_comb begin
    if (state == ST_SCAN) begin
      raddr = scan_idx + FW'(1);
    end else if (func == FUNC_ADD) begin
      raddr = fl_in;
    end else begin
      raddr = '0;
    end
  end

  always_comb begin
    cmp_b = car;
    case (state)
      ST_REQ:  cmp_a = fl_q;
      ST_SCAN: cmp_a = scan_idx;
      ST_SEL:  cmp_a = pick;
      ST_MOVE: begin
        cmp_a = car_step;
        cmp_b = goal;
      end
      default: cmp_a = fl_q;
    endcase
  end

  assign diff     = {1'b0, cmp_a} - {1'b0, cmp_b};
  assign diff_neg = '0 - diff;
  assign a_ge_b   = ~diff[FW];
  assign a_eq_b   = (cmp_a == cmp_b);
  assign span     = a_ge_b ? diff[FW-1:0] : diff_neg[FW-1:0];

  // request merge
  always_comb begin
    case (kind_q)
      KIND_UP:   want = REQ_UP;
      KIND_DOWN: want = REQ_DOWN;
      default:   want = a_ge_b ? REQ_UP : REQ_DOWN;
    endcase
    at_car = ((mode == MODE_WAITING) || (mode == MODE_REACHED)) && a_eq_b;
    base   = at_car ? REQ_NONE : entry;
    if (base == want) begin
      merged = base;
    end else if (base == REQ_NONE) begin
      merged = want;
    end else begin
      merged = REQ_BOTH;
    end
  end

  assign ram_we = (state == ST_REQ);

  // target choice after the sweep
  always_comb begin
    case (dir)
      DIR_UP:   pick = up_found ? up_floor : (dn_found ? dn_floor : nr_floor);
      DIR_DOWN: pick = dn_found ? dn_floor : (up_found ? up_floor : nr_floor);
      default:  pick = nr_floor;
    endcase
  end

  always_comb begin
    if ((dir == DIR_UP) && (car != LAST)) begin
      car_step = car + FW'(1);
    end else if ((dir == DIR_DOWN) && (car != '0)) begin
      car_step = car - FW'(1);
    end else begin
      car_step = car;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_ADD:    state_next = bad_req ? ST_DONE : ST_REQ;
            FUNC_SELECT: state_next = ST_SCAN;
            FUNC_MOVE:   state_next = ST_MOVE;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_REQ:  state_next = ST_DONE;
      ST_SCAN: state_next = (scan_idx == LAST) ? ST_SEL : ST_SCAN;
      ST_SEL:  state_next = ST_DONE;
      ST_MOVE: state_next = ST_DONE;
      ST_DONE: state_next = out_ready ? ST_IDLE : ST_DONE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_vld <= req_vld[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_WAITING;
      dir      <= DIR_NONE;
      goal_vld <= 1'b0;
      car      <= '0;
      req_vld  <= '0;
    end else begin
      if (cfg_we) begin
        car <= cfg_clamped;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            fl_q            <= fl_in;
            kind_q          <= req_kind;
            doors_open      <= 1'b0;
            retarget_wanted <= 1'b0;
            target_valid    <= 1'b0;
            tfloor_q        <= '0;
            arrived         <= 1'b0;
            keep_moving     <= 1'b0;
            ignored         <= (func == FUNC_ADD) ? bad_req :
                               ((func != FUNC_SELECT) && (func != FUNC_MOVE));
            scan_idx        <= '0;
            up_found        <= 1'b0;
            dn_found        <= 1'b0;
            nr_found        <= 1'b0;
          end
        end
        ST_REQ: begin
          doors_open      <= at_car;
          retarget_wanted <= (base != want);
          req_vld[fl_q]   <= 1'b1;
        end
        ST_SCAN: begin
          // lowest up call at or above the car
          if (entry[0] && a_ge_b && !up_found) begin
            up_found <= 1'b1;
            up_floor <= scan_idx;
          end
          // highest down call at or below the car: keep overwriting
          if (entry[1] && (!a_ge_b || a_eq_b)) begin
            dn_found <= 1'b1;
            dn_floor <= scan_idx;
          end
          // strict compare lets the lower floor win a tie
          if ((entry != REQ_NONE) && (!nr_found || (span < best_dist))) begin
            nr_found  <= 1'b1;
            nr_floor  <= scan_idx;
            best_dist <= span;
          end
          scan_idx <= scan_idx + FW'(1);
        end
        ST_SEL: begin
          if (!nr_found) begin
            mode <= MODE_WAITING;
          end else begin
            mode         <= MODE_UPDATING;
            goal_vld     <= 1'b1;
            goal         <= pick;
            target_valid <= 1'b1;
            tfloor_q     <= pick;
            if (a_eq_b) begin
              dir <= DIR_NONE;
            end else if (a_ge_b) begin
              dir <= DIR_UP;
            end else begin
              dir <= DIR_DOWN;
            end
          end
        end
        ST_MOVE: begin
          if ((mode != MODE_UPDATING) && (mode != MODE_MOVING)) begin
            ignored <= 1'b1;
          end else begin
            car <= car_step;
            if (goal_vld && a_eq_b) begin
              mode              <= MODE_REACHED;
              req_vld[car_step] <= 1'b0;
              goal_vld          <= 1'b0;
              arrived           <= 1'b1;
            end else begin
              mode        <= MODE_MOVING;
              keep_moving <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
